FILE: src/sle_pkg.sv
// Package for the sequential list engine: sizes, action and status codes, word types.
// Used by every module in src; depends on nothing.
package sle_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Action codes.
   localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
   localparam logic [3:0] ACT_POP_BACK   = 4'd1;
   localparam logic [3:0] ACT_PUSH_FRONT = 4'd2;
   localparam logic [3:0] ACT_POP_FRONT  = 4'd3;
   localparam logic [3:0] ACT_INSERT     = 4'd4;
   localparam logic [3:0] ACT_ERASE      = 4'd5;
   localparam logic [3:0] ACT_FIND       = 4'd6;
   localparam logic [3:0] ACT_OVERWRITE  = 4'd7;
   localparam logic [3:0] ACT_SORT       = 4'd8;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [3:0]         action;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] found_index;
      logic [6:0] entry_count;
   } rsp_word_type;

   // Queue word from front to back.
   typedef struct packed {
      logic [3:0]            action;
      logic [IDX_W-1:0]      position;
      logic [DATA_WIDTH-1:0] value;
   } cmd_word_type;

endpackage

FILE: src/sle_front.sv
// Front end of the list engine: accepts request words into a short queue.
// Depends on sle_pkg.
module sle_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sle_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output sle_pkg::cmd_word_type cmd_word
);

   sle_pkg::cmd_word_type q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  push, pop;
   sle_pkg::cmd_word_type conv;

   // Trim the value to the stored width.
   always_comb begin
      conv.action   = req_word.action;
      conv.position = sle_pkg::IDX_W'(req_word.position);
      conv.value    = sle_pkg::DATA_WIDTH'(req_word.value);
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_word  = q_ff[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= conv;
      end
   end

   // The queue never holds more than two words.
   a_fill_max: assert property (@(posedge clock) disable iff (reset) fill_ff <= 2'd2)
      else $error("queue overfilled");
   // A pop leaves the fill one lower unless a push arrived too.
   a_fill_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> fill_ff == $past(fill_ff) - 2'd1)
      else $error("queue fill mismatch on pop");
   a_fill_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("queue fill mismatch on push");

endmodule

FILE: src/sle_back.sv
// Back end of the list engine: the list memory and the sequencer that runs each action.
// Depends on sle_pkg.
module sle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_take,
   input  sle_pkg::cmd_word_type cmd_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sle_pkg::rsp_word_type rsp_word
);

   localparam int IW = sle_pkg::IDX_W;
   localparam int CW = sle_pkg::CNT_W;
   localparam int DW = sle_pkg::DATA_WIDTH;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_STEP  = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;
   localparam logic [2:0] S_REPLY = 3'd4;

   // Walk kinds.
   localparam logic [2:0] W_UP   = 3'd0;
   localparam logic [2:0] W_DOWN = 3'd1;
   localparam logic [2:0] W_FIND = 3'd2;
   localparam logic [2:0] W_SORT = 3'd3;

   logic [DW-1:0] mem [sle_pkg::CAPACITY];
   logic [DW-1:0] rd_data_ff;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    walk_ff, walk_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] stop_ff, stop_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic          swapped_ff, swapped_in;
   logic [DW-1:0] hold_ff, hold_in;
   logic [DW-1:0] key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_word_type rsp_ff, rsp_in;
   logic [2:0]    status_ff, status_in;
   logic [IW-1:0] found_ff, found_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data;
   logic          full, empty;
   logic          hold_less;

   assign full      = (count_ff == CW'(sle_pkg::CAPACITY));
   assign empty     = (count_ff == '0);
   assign hold_less = $signed(hold_ff) < $signed(rd_data_ff);
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Sequencer: one memory read and at most one write each cycle.
   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      stop_in      = stop_ff;
      pass_in      = pass_ff;
      swapped_in   = swapped_ff;
      hold_in      = hold_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = hold_ff;
      rd_addr      = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               status_in = sle_pkg::ST_OK;
               found_in  = '0;
               key_in    = cmd_word.value;
               hold_in   = cmd_word.value;
               state_in  = S_DONE;
               case (cmd_word.action)
                  sle_pkg::ACT_PUSH_BACK: begin
                     if (full) status_in = sle_pkg::ST_FULL;
                     else begin
                        wr_en    = 1'b1;
                        wr_addr  = IW'(count_ff);
                        wr_data  = cmd_word.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sle_pkg::ACT_POP_BACK: begin
                     if (empty) status_in = sle_pkg::ST_EMPTY;
                     else count_in = count_ff - 1'b1;
                  end
                  sle_pkg::ACT_PUSH_FRONT, sle_pkg::ACT_INSERT: begin
                     if (full) status_in = sle_pkg::ST_FULL;
                     else if (cmd_word.action == sle_pkg::ACT_INSERT &&
                              CW'(cmd_word.position) > count_ff)
                        status_in = sle_pkg::ST_RANGE;
                     else begin
                        // Carry entries up, from the insertion point to the end.
                        walk_in = W_UP;
                        idx_in  = (cmd_word.action == sle_pkg::ACT_INSERT) ?
                                  cmd_word.position : '0;
                        stop_in = count_ff;
                        state_in = S_READ;
                     end
                  end
                  sle_pkg::ACT_POP_FRONT, sle_pkg::ACT_ERASE: begin
                     if (empty) status_in = sle_pkg::ST_EMPTY;
                     else if (cmd_word.action == sle_pkg::ACT_ERASE &&
                              CW'(cmd_word.position) >= count_ff)
                        status_in = sle_pkg::ST_RANGE;
                     else begin
                        walk_in  = W_DOWN;
                        idx_in   = (cmd_word.action == sle_pkg::ACT_ERASE) ?
                                   cmd_word.position : '0;
                        stop_in  = count_ff - 1'b1;
                        state_in = S_READ;
                     end
                  end
                  sle_pkg::ACT_FIND: begin
                     if (empty) status_in = sle_pkg::ST_EMPTY;
                     else begin
                        walk_in   = W_FIND;
                        idx_in    = '0;
                        stop_in   = count_ff;
                        status_in = sle_pkg::ST_NOTFOUND;
                        state_in  = S_READ;
                     end
                  end
                  sle_pkg::ACT_OVERWRITE: begin
                     if (empty) status_in = sle_pkg::ST_EMPTY;
                     else if (CW'(cmd_word.position) >= count_ff)
                        status_in = sle_pkg::ST_RANGE;
                     else begin
                        wr_en   = 1'b1;
                        wr_addr = cmd_word.position;
                        wr_data = cmd_word.value;
                     end
                  end
                  sle_pkg::ACT_SORT: begin
                     if (count_ff > CW'(1)) begin
                        walk_in    = W_SORT;
                        idx_in     = '0;
                        pass_in    = count_ff - 1'b1;
                        swapped_in = 1'b0;
                        state_in   = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // Read the entry under idx; for an erase or pop front the one above it; for sort,
            // the first of the pair.
            rd_addr = (walk_ff == W_DOWN) ? idx_ff + 1'b1 : idx_ff;
            if (walk_ff == W_SORT) hold_in = '0;
            state_in = S_STEP;
         end
         S_STEP: begin
            case (walk_ff)
               W_UP: begin
                  // Write the carried word here, carry the old entry onward.
                  wr_en   = 1'b1;
                  wr_addr = idx_ff;
                  wr_data = hold_ff;
                  hold_in = rd_data_ff;
                  if (CW'(idx_ff) == stop_ff) begin
                     count_in = count_ff + 1'b1;
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     rd_addr  = idx_ff + 1'b1;
                  end
               end
               W_DOWN: begin
                  // rd_data holds entry idx+1; move it down and read the next one.
                  if (CW'(idx_ff) == stop_ff) begin
                     count_in = count_ff - 1'b1;
                     state_in = S_DONE;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = idx_ff;
                     wr_data = rd_data_ff;
                     idx_in  = idx_ff + 1'b1;
                     rd_addr = idx_ff + IW'(2);
                  end
               end
               W_FIND: begin
                  if (rd_data_ff == key_ff) begin
                     status_in = sle_pkg::ST_OK;
                     found_in  = idx_ff;
                     state_in  = S_DONE;
                  end else if (CW'(idx_ff) + 1'b1 == stop_ff) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     rd_addr  = idx_ff + 1'b1;
                  end
               end
               W_SORT: begin
                  // hold_ff gets entry j on the first step, then compares with j+1.
                  if (!swapped_ff) begin
                     hold_in    = rd_data_ff;
                     swapped_in = 1'b1;
                     rd_addr    = idx_ff + 1'b1;
                  end else begin
                     swapped_in = 1'b0;
                     if (hold_less) begin
                        wr_en   = 1'b1;
                        wr_addr = idx_ff;
                        wr_data = rd_data_ff;
                        found_in = '1;
                     end else begin
                        found_in = '0;
                     end
                     state_in = S_REPLY;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_REPLY: begin
            // Second half of a sort swap, then advance the pair.
            if (found_ff == '1) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff + 1'b1;
               wr_data = hold_ff;
            end
            found_in = '0;
            if (CW'(idx_ff) + 1'b1 >= pass_ff) begin
               idx_in = '0;
               if (pass_ff <= CW'(1)) state_in = S_DONE;
               else begin
                  pass_in  = pass_ff - 1'b1;
                  state_in = S_READ;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.found_index  = 6'(found_ff);
               rsp_in.entry_count  = 7'(count_ff);
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         swapped_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         swapped_ff   <= swapped_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff   <= walk_in;
      idx_ff    <= idx_in;
      stop_ff   <= stop_in;
      pass_ff   <= pass_in;
      hold_ff   <= hold_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   // List memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // The count never exceeds the capacity.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sle_pkg::CAPACITY))
      else $error("entry count above capacity");
   // The count moves by at most one per action.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");
   // No new command is taken while a result is being built.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == S_IDLE)
      else $error("command taken while busy");

endmodule

FILE: src/sequential_list_engine.sv
// Sequential list engine: a bounded ordered list of signed words.
//
// The req_ channel carries one action word (action, position, value); the rsp_
// channel returns one word per action (status, found_index, entry_count), in order.
// A word moves at a clock edge where valid is high and stall is low.
// The front end queues up to two request words; the back end runs one action
// at a time against a list memory with one write port and one registered read.
// Push back, pop back, overwrite and every rejected action go from idle through the
// done state to the result. Insert and push front walk the entries from the position
// to the end, erase and pop front likewise, find walks from the first entry until a
// match or the end, and sort runs bubble passes over neighbouring pairs.
// Reset (synchronous, active high) empties the list and the queue; the memory
// contents are left as they are, and entries at or above the count never reach a result.
// When rsp_stall is high the result holds; the back end waits with the next
// result and the queue fills, then req_stall rises.
// Depends on sle_pkg, sle_front and sle_back.
module sequential_list_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sle_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sle_pkg::rsp_word_type rsp_word
);

   logic                  cmd_valid;
   logic                  cmd_take;
   sle_pkg::cmd_word_type cmd_word;

   sle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_word  (cmd_word)
   );

   sle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_word  (cmd_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sequential list engine: drives list actions,
// predicts each result word from a shadow list and compares in order.
// Depends on sle_pkg and the sequential_list_engine RTL.
`timescale 1ns / 100ps

module testbench;

   // Action codes that the block does not define.
   localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
   localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   sle_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   sle_pkg::rsp_word_type rsp_word;

   // Shadow copy of the list and its count.
   logic signed [31:0]    shadow_list [sle_pkg::CAPACITY];
   int                    shadow_count;
   sle_pkg::rsp_word_type pending_rsp [$];
   int                    error_count = 0;
   int                    stall_mode = 0;

   sequential_list_engine dut (.*);

   always #5 clock = ~clock;

   // Compute the result word for one action and update the shadow list.
   function automatic sle_pkg::rsp_word_type apply_action(sle_pkg::req_word_type w);
      sle_pkg::rsp_word_type r;
      int                    pos;
      logic signed [31:0]    t;
      r = '0;
      pos = w.position;
      case (w.action)
         sle_pkg::ACT_PUSH_BACK, sle_pkg::ACT_PUSH_FRONT, sle_pkg::ACT_INSERT: begin
            if (w.action == sle_pkg::ACT_PUSH_BACK) pos = shadow_count;
            if (w.action == sle_pkg::ACT_PUSH_FRONT) pos = 0;
            if (shadow_count >= sle_pkg::CAPACITY) r.status = sle_pkg::ST_FULL;
            else if (pos > shadow_count) r.status = sle_pkg::ST_RANGE;
            else begin
               for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = w.value;
               shadow_count++;
            end
         end
         sle_pkg::ACT_POP_BACK: begin
            if (shadow_count == 0) r.status = sle_pkg::ST_EMPTY;
            else shadow_count--;
         end
         sle_pkg::ACT_POP_FRONT, sle_pkg::ACT_ERASE: begin
            if (w.action == sle_pkg::ACT_POP_FRONT) pos = 0;
            if (shadow_count == 0) r.status = sle_pkg::ST_EMPTY;
            else if (pos >= shadow_count) r.status = sle_pkg::ST_RANGE;
            else begin
               for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         sle_pkg::ACT_FIND: begin
            if (shadow_count == 0) r.status = sle_pkg::ST_EMPTY;
            else begin
               r.status = sle_pkg::ST_NOTFOUND;
               for (int i = 0; i < shadow_count; i++)
                  if (shadow_list[i] == w.value) begin
                     r.status = sle_pkg::ST_OK;
                     r.found_index = 6'(i);
                     break;
                  end
            end
         end
         sle_pkg::ACT_OVERWRITE: begin
            if (shadow_count == 0) r.status = sle_pkg::ST_EMPTY;
            else if (pos >= shadow_count) r.status = sle_pkg::ST_RANGE;
            else shadow_list[pos] = w.value;
         end
         sle_pkg::ACT_SORT: begin
            // Stable bubble sort, largest signed value first.
            for (int i = 0; i + 1 < shadow_count; i++)
               for (int j = 0; j + 1 < shadow_count - i; j++)
                  if (shadow_list[j] < shadow_list[j+1]) begin
                     t = shadow_list[j];
                     shadow_list[j] = shadow_list[j+1];
                     shadow_list[j+1] = t;
                  end
         end
         default: ;
      endcase
      r.entry_count = 7'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Send one word; the expectation is queued when the word is accepted.
   // Valid stays high so that the next word can follow at once.
   task automatic send_word(logic [3:0] act, int pos, logic signed [31:0] val);
      sle_pkg::req_word_type w;
      w.action = act;
      w.position = pos[5:0];
      w.value = val;
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_action(w));
      @(negedge clock);
   endtask

   // Drop valid between bursts.
   task automatic idle_sender();
      if (req_valid) req_valid <= 1'b0;
   endtask

   // Random burst gaps on the sending side.
   task automatic sender_gap();
      if ($urandom_range(0, 3) == 0) begin
         idle_sender();
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Check each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      sle_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) report_mismatch("unexpected word", 1, 0);
         else begin
            want = pending_rsp.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", int'(rsp_word.status), int'(want.status));
            if (rsp_word.found_index !== want.found_index)
               report_mismatch("found_index", int'(rsp_word.found_index),
                               int'(want.found_index));
            if (rsp_word.entry_count !== want.entry_count)
               report_mismatch("entry_count", int'(rsp_word.entry_count),
                               int'(want.entry_count));
         end
      end
   end

   // Receiver stall pattern, changing mode over the run.
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 15)) - 8;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic drain();
      idle_sender();
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Directed: empty cases, extremes, every action, unused action codes, bad positions.
   task automatic test_directed();
      send_word(sle_pkg::ACT_POP_BACK, 0, 0);
      send_word(sle_pkg::ACT_POP_FRONT, 0, 0);
      send_word(sle_pkg::ACT_ERASE, 0, 0);
      send_word(sle_pkg::ACT_FIND, 0, 0);
      send_word(sle_pkg::ACT_OVERWRITE, 0, 0);
      send_word(sle_pkg::ACT_SORT, 0, 0);
      send_word(sle_pkg::ACT_INSERT, 1, 5);
      send_word(sle_pkg::ACT_INSERT, 0, 32'sh7fffffff);
      send_word(sle_pkg::ACT_PUSH_BACK, 0, 32'sh80000000);
      send_word(sle_pkg::ACT_PUSH_FRONT, 63, -1);
      send_word(sle_pkg::ACT_INSERT, 3, 7);
      send_word(sle_pkg::ACT_INSERT, 1, 7);
      send_word(sle_pkg::ACT_FIND, 0, 7);
      send_word(sle_pkg::ACT_FIND, 0, 12345);
      send_word(sle_pkg::ACT_OVERWRITE, 4, 0);
      send_word(sle_pkg::ACT_OVERWRITE, 63, 0);
      send_word(sle_pkg::ACT_ERASE, 5, 0);
      send_word(sle_pkg::ACT_SORT, 0, 0);
      send_word(sle_pkg::ACT_ERASE, 1, 0);
      send_word(ACT_UNUSED_LO, 0, 0);
      send_word(ACT_UNUSED_HI, 63, -1);
      drain();
   endtask

   // Fill to capacity, check full handling, then empty again.
   task automatic test_full_list();
      while (shadow_count < sle_pkg::CAPACITY)
         send_word(sle_pkg::ACT_PUSH_BACK, 0, pick_value());
      send_word(sle_pkg::ACT_PUSH_BACK, 0, 1);
      send_word(sle_pkg::ACT_PUSH_FRONT, 0, 1);
      send_word(sle_pkg::ACT_INSERT, 63, 1);
      send_word(sle_pkg::ACT_FIND, 0, shadow_list[63]);
      send_word(sle_pkg::ACT_SORT, 0, 0);
      send_word(sle_pkg::ACT_ERASE, 63, 0);
      send_word(sle_pkg::ACT_INSERT, 63, -2);
      while (shadow_count > 0) send_word(sle_pkg::ACT_POP_FRONT, 0, 0);
      drain();
   endtask

   // Random actions, weighted toward valid positions and small lists.
   task automatic test_random(int n);
      logic [3:0] act;
      int         pos;
      for (int k = 0; k < n; k++) begin
         sender_gap();
         if (k == n / 2) drain();
         act = (shadow_count > 20) ? 4'($urandom_range(0, sle_pkg::ACT_SORT))
                                   : 4'($urandom_range(0, sle_pkg::ACT_OVERWRITE));
         if ($urandom_range(0, 40) == 0) act = 4'($urandom_range(0, ACT_UNUSED_HI));
         if (shadow_count < 6 && $urandom_range(0, 1)) act = sle_pkg::ACT_PUSH_BACK;
         if (shadow_count > 40 && $urandom_range(0, 1)) act = sle_pkg::ACT_POP_BACK;
         pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(0, shadow_count);
         if (act == sle_pkg::ACT_SORT && $urandom_range(0, 3) != 0) act = sle_pkg::ACT_FIND;
         if (act == sle_pkg::ACT_FIND && shadow_count > 0 && $urandom_range(0, 1))
            send_word(act, pos, shadow_list[$urandom_range(0, shadow_count - 1)]);
         else
            send_word(act, pos, pick_value());
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      shadow_count = 0;
      test_directed();
      stall_mode = 1;
      test_full_list();
      stall_mode = 2;
      test_random(800);
      stall_mode = 1;
      test_random(800);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

endmodule
